### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// one-line wrappers around concurrent assertions, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LRRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LRRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lrra_pkg.sv
// ----------------------------------------------------------------------------
// lrra_pkg
// field widths, saturation limit and sequencer states of the log ring allocator
// ----------------------------------------------------------------------------
`default_nettype none

package lrra_pkg;

  localparam int MSG_W    = 12;  // message length field
  localparam int OFFSET_W = 12;  // record offset field
  localparam int SEQ_W    = 32;  // sequence numbers
  localparam int DROP_W   = 10;  // dropped record count
  localparam int NEED_W   = 13;  // header + length + terminator, bytes

  localparam logic [DROP_W-1:0] DROP_SAT = {DROP_W{1'b1}};

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DIV      = 9'b000000100,
    S_LOOP     = 9'b000001000,
    S_DROP_RD  = 9'b000010000,
    S_DROP_CHK = 9'b000100000,
    S_DROP_WR  = 9'b001000000,
    S_PLACE    = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

### src/lrra_ram.sv
// ----------------------------------------------------------------------------
// lrra_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lrra_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/log_ring_record_allocator_top.sv
// ----------------------------------------------------------------------------
// log_ring_record_allocator_top
// space allocator for variable-length records in an overwriting byte ring
// ----------------------------------------------------------------------------
// Raise start with message_length_i while busy is low; that request is taken
// on the clock edge. Exactly one result follows, shown for a single cycle with
// done_o high, and it must be captured in that cycle since the result side
// cannot stall. An allocation steps through span, check, place, result and
// idle before the next request is taken. Every old record dropped while
// trimming adds the steps read, check, write back and check again, a drop
// after placing adds read, check and write back, and every wrap to offset
// zero adds another check; each drop reads the oldest record's span
// and the slot after it, then marks it dropped in the slot length ram.
// A request whose record needs more bytes than the whole ring shows status_o
// in the cycle right after the request edge, with done_o, then goes idle.
// After reset the block clears the slot length ram, one entry a cycle, all
// ceil(RING_BYTES / ALIGN_BYTES) entries (512 at the defaults) with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module log_ring_record_allocator_top #(
  parameter int unsigned RING_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [lrra_pkg::MSG_W-1:0]    message_length_i,
  output logic                          busy,
  output logic                          done_o,
  output logic                          status_o,
  output logic [lrra_pkg::OFFSET_W-1:0] record_offset_o,
  output logic [lrra_pkg::SEQ_W-1:0]    record_sequence_o,
  output logic [lrra_pkg::SEQ_W-1:0]    oldest_sequence_o,
  output logic [lrra_pkg::DROP_W-1:0]   dropped_count_o
);

  import lrra_pkg::*;

  // ring is kept in units of alignment slots, offsets are always slot aligned
  localparam int SLOT_COUNT = (RING_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SPAN_W     = SLOT_W + 1;  // slots covered by one record
  localparam int NXT_W      = SLOT_W + 2;  // slot + span before wrap check
  // first slot whose offset leaves no more than a header before the ring end
  localparam int WRAP_SLOT  = (RING_BYTES - HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int LOOP_LIMIT = 4 * SLOT_COUNT + 8;
  localparam int ITER_W     = $clog2(LOOP_LIMIT + 1);
  localparam int CMP_W      = ($clog2(RING_BYTES) + 2 > NEED_W + 1) ?
                              $clog2(RING_BYTES) + 2 : NEED_W + 1;
  // reciprocal for the ceil(need / align) step: floor, then one correction
  localparam int RECIP_W    = NEED_W + 1;
  localparam int RECIP      = (1 << NEED_W) / ALIGN_BYTES;
  localparam int PROD_W     = NEED_W + RECIP_W;

  localparam logic [SPAN_W-1:0] DROP_MARK = {SPAN_W{1'b1}};
  localparam logic [SPAN_W-1:0] WRAP_MARK = '0;

  // sequencer and architectural state
  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   ws_q, ws_d;        // write offset, slots
  logic [SLOT_W-1:0]   os_q, os_d;        // oldest offset, slots
  logic [SEQ_W-1:0]    oseq_q, oseq_d;    // oldest sequence
  logic [SEQ_W-1:0]    nseq_q, nseq_d;    // newest sequence
  logic [DROP_W-1:0]   drops_q, drops_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;

  // per-request working registers
  logic [NEED_W-1:0]   need_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SPAN_W-1:0]   span_q;
  logic [ITER_W-1:0]   iter_q;
  logic [SLOT_W-1:0]   nxt_q;
  logic [SLOT_W-1:0]   placed_q;
  logic                nospace_q;
  logic                ret_done_q;       // drop walk returns to result, not loop

  // slot length ram port
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [SPAN_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [SPAN_W-1:0]   ram_rdata;

  // request decode
  logic [NEED_W-1:0]   need_in;
  logic                nospace_in;
  logic                accept;

  // span: ceil(need / align) from the registered reciprocal product
  logic [NEED_W-1:0]   q0;
  logic [NEED_W-1:0]   rem;
  logic [NEED_W:0]     span_full;

  // loop decisions
  logic [SLOT_W-1:0]   gap;
  logic                os_gt;
  logic                short_gap;
  logic                end_short;
  logic                iter_done;

  // next-offset arithmetic for placing and for dropping
  logic [NXT_W-1:0]    place_sum;
  logic [SLOT_W-1:0]   place_nxt;
  logic [NXT_W-1:0]    drop_sum;
  logic [SLOT_W-1:0]   drop_nxt;

  assign accept     = start && !busy;
  assign need_in    = NEED_W'(HEADER_BYTES) + NEED_W'(message_length_i) + NEED_W'(1);
  assign nospace_in = CMP_W'(need_in) > CMP_W'(RING_BYTES);

  assign q0        = NEED_W'(prod_q >> NEED_W);
  assign rem       = need_q - NEED_W'(q0 * ALIGN_BYTES);
  // remainder lies below twice the alignment, so at most two steps up
  assign span_full = {1'b0, q0} + (NEED_W + 1)'(rem != '0)
                   + (NEED_W + 1)'(rem > NEED_W'(ALIGN_BYTES));

  assign os_gt     = os_q > ws_q;
  assign gap       = os_q - ws_q;
  assign short_gap = {1'b0, gap} < span_q;
  // room to the ring end is short when write offset + need passes the end
  assign end_short = CMP_W'(ws_q * ALIGN_BYTES) + CMP_W'(need_q) > CMP_W'(RING_BYTES);
  assign iter_done = iter_q == ITER_W'(LOOP_LIMIT);

  assign place_sum = NXT_W'(ws_q) + NXT_W'(span_q);
  assign place_nxt = (place_sum >= NXT_W'(WRAP_SLOT)) ? '0 : SLOT_W'(place_sum);
  // ram_rdata holds the oldest record's span during the check step
  assign drop_sum  = NXT_W'(os_q) + NXT_W'(ram_rdata);
  assign drop_nxt  = (drop_sum >= NXT_W'(WRAP_SLOT)) ? '0 : SLOT_W'(drop_sum);

  // sequencer: one memory access pattern per state
  always_comb begin
    state_d   = state_q;
    ws_d      = ws_q;
    os_d      = os_q;
    oseq_d    = oseq_q;
    nseq_d    = nseq_q;
    drops_d   = drops_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = ws_q;
    ram_wdata = WRAP_MARK;
    ram_raddr = os_q;
    unique case (state_q)
      S_CLEAR: begin
        // walk every slot to the wrap marker value after reset
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = WRAP_MARK;
        clr_d     = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(SLOT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          drops_d = '0;
          state_d = nospace_in ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        state_d = S_LOOP;
      end
      S_LOOP: begin
        priority if (iter_done) begin
          // bounded search gave up, place at the current write offset
          state_d = S_PLACE;
        end else if (os_gt) begin
          state_d = short_gap ? S_DROP_RD : S_PLACE;
        end else if (end_short) begin
          // leave a wrap marker and restart at offset zero
          ram_we    = 1'b1;
          ram_waddr = ws_q;
          ram_wdata = WRAP_MARK;
          ws_d      = '0;
          state_d   = (os_q == '0) ? S_DROP_RD : S_LOOP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DROP_RD: begin
        // read span of the oldest record
        ram_raddr = os_q;
        state_d   = S_DROP_CHK;
      end
      S_DROP_CHK: begin
        // look at the slot that becomes oldest: a wrap marker sends it to zero
        ram_raddr = drop_nxt;
        oseq_d    = oseq_q + SEQ_W'(1);
        drops_d   = (drops_q == DROP_SAT) ? drops_q : drops_q + DROP_W'(1);
        state_d   = S_DROP_WR;
      end
      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = os_q;
        ram_wdata = DROP_MARK;
        os_d      = (ram_rdata == WRAP_MARK) ? '0 : nxt_q;
        state_d   = ret_done_q ? S_DONE : S_LOOP;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = ws_q;
        ram_wdata = span_q;
        nseq_d    = nseq_q + SEQ_W'(1);
        ws_d      = place_nxt;
        // write offset catching up with the oldest means full: drop one more
        state_d   = (os_q == place_nxt) ? S_DROP_RD : S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ws_q    <= '0;
      os_q    <= '0;
      oseq_q  <= SEQ_W'(1);
      nseq_q  <= '0;
      drops_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      ws_q    <= ws_d;
      os_q    <= os_d;
      oseq_q  <= oseq_d;
      nseq_q  <= nseq_d;
      drops_q <= drops_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      need_q    <= need_in;
      nospace_q <= nospace_in;
      prod_q    <= PROD_W'(need_in) * PROD_W'(RECIP);
      iter_q    <= '0;
    end
    if (state_q == S_DIV) begin
      span_q <= SPAN_W'(span_full);
    end
    if (state_q == S_LOOP && !iter_done) begin
      iter_q     <= iter_q + ITER_W'(1);
      ret_done_q <= 1'b0;
    end
    if (state_q == S_DROP_CHK) begin
      nxt_q <= drop_nxt;
    end
    if (state_q == S_PLACE) begin
      placed_q   <= ws_q;
      ret_done_q <= 1'b1;
    end
  end

  lrra_ram #(
    .WIDTH (SPAN_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result
  assign busy              = state_q != S_IDLE;
  assign done_o            = state_q == S_DONE;
  assign status_o          = nospace_q;
  assign record_offset_o   = nospace_q ? '0 : OFFSET_W'(placed_q * ALIGN_BYTES);
  assign record_sequence_o = nospace_q ? '0 : nseq_q;
  assign oldest_sequence_o = oseq_q;
  assign dropped_count_o   = drops_q;

  `LRRA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, busy, "request not taken")
  `LRRA_ASSERT_NEXT(a_nospace_fast, clk_i, rst_ni, accept && nospace_in, done_o, "late no-space")
  `LRRA_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result held over")
  `LRRA_ASSERT_NOW(a_iter_bounded, clk_i, rst_ni, state_q == S_LOOP,
                   iter_q <= ITER_W'(LOOP_LIMIT), "search bound passed")
  `LRRA_ASSERT_NOW(a_offsets_in_ring, clk_i, rst_ni, state_q == S_IDLE,
                   ws_q < SLOT_W'(SLOT_COUNT - 1) || ws_q == SLOT_W'(SLOT_COUNT - 1),
                   "write offset past ring")

endmodule

`default_nettype wire
